[sv/efws_pkg.sv]
// Shared types and constants for the earliest-free worker scheduler.
// No dependencies; every other file imports this package.
package efws_pkg;

  localparam int TIME_W  = 48;
  localparam int DUR_W   = 32;
  localparam int WIDX_W  = 4;
  localparam int CFG_W   = 5;
  localparam int MAX_IDX = 16;   // worker indices that WIDX_W bits can name

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [DUR_W-1:0]  dur_t;
  typedef logic [WIDX_W-1:0] widx_t;
  typedef logic [CFG_W-1:0]  cfg_t;

  // controls broadcast to every cell of the ring
  typedef struct packed {
    logic shift;   // rotate ring one place toward cell 0
    logic clear;   // zero every free time
  } cell_ctl_t;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

endpackage

[sv/efws_cell.sv]
// One ring cell: holds the next-free time of one worker.
// Depends on efws_pkg.
module efws_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  efws_pkg::cell_ctl_t ctl,
  input  efws_pkg::time_t    shift_in,
  input  logic               wr_en,
  input  efws_pkg::time_t    wr_data,
  output efws_pkg::time_t    value
);
  import efws_pkg::*;

  time_t value_r;
  time_t value_nxt;

  always_comb begin
    priority if (ctl.clear) begin
      value_nxt = '0;
    end else if (wr_en) begin
      value_nxt = wr_data;
    end else if (ctl.shift) begin
      value_nxt = shift_in;
    end else begin
      value_nxt = value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= '0;
    end else begin
      value_r <= value_nxt;
    end
  end

  assign value = value_r;

endmodule

[sv/efws_min.sv]
// Running-minimum tracker fed by the head of the ring, one worker per cycle.
// Depends on efws_pkg.
module efws_min (
  input  logic            clk,
  input  logic            first,     // first worker of a scan: load unconditionally
  input  logic            cand_en,   // candidate is an active worker
  input  efws_pkg::time_t cand_val,
  input  efws_pkg::widx_t cand_idx,
  output efws_pkg::time_t min_val,
  output efws_pkg::widx_t min_idx
);
  import efws_pkg::*;

  time_t min_val_r;
  time_t min_val_nxt;
  widx_t min_idx_r;
  widx_t min_idx_nxt;

  always_comb begin
    min_val_nxt = min_val_r;
    min_idx_nxt = min_idx_r;
    // strict compare keeps the lower index on a tie
    if (first || (cand_en && (cand_val < min_val_r))) begin
      min_val_nxt = cand_val;
      min_idx_nxt = cand_idx;
    end
  end

  always_ff @(posedge clk) begin
    min_val_r <= min_val_nxt;
    min_idx_r <= min_idx_nxt;
  end

  assign min_val = min_val_r;
  assign min_idx = min_idx_r;

endmodule

[sv/earliest_free_worker_scheduler.sv]
// Earliest-free worker scheduler: top level with ring control and result register.
// Depends on efws_pkg, efws_cell and efws_min.
//
// Each job duration word is assigned to the active worker with the smallest
// next-free time (lowest index on a tie); the result word carries that worker
// and the job's start time, and the worker's free time then advances by the
// duration, saturating at 2^48-1. Free times live in a ring of NUM_WORKERS
// cells that rotates one place per cycle while scanning, past a single
// 48-bit comparator; a scan visits every cell, then an update writes the
// winner's free time and the result, waiting while the previous result is
// still unread. A job is taken only in idle, not before the last one is
// written to the result register. The next job is taken as soon as the
// block returns to idle, while the previous result may still wait on the output.
// Only workers 0 .. active_workers-1 compete; a count of 0 acts as 1 and
// counts above 16 (or above NUM_WORKERS, if fewer) act as that limit. Any
// configuration write clears all free times.
module earliest_free_worker_scheduler #(
  parameter int NUM_WORKERS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // config: [4:0] active_workers
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_tdata,
  // in: [31:0] job_duration
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  // out: [3:0] worker_index, [51:4] start_time, [55:52] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata
);
  import efws_pkg::*;

  localparam int CNT_W = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_WORKERS - 1);

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  cfg_t             active_r;
  dur_t             dur_r;
  logic             out_valid_r;
  time_t            out_start_r;
  widx_t            out_idx_r;

  cell_ctl_t        ctl;
  time_t            cell_val [NUM_WORKERS];
  logic             do_update;
  cfg_t             lim;
  logic             cand_en;
  time_t            min_val;
  widx_t            min_idx;
  logic [TIME_W:0]  sum;
  time_t            next_time;

  logic in_acc, out_acc, cfg_acc;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign out_acc   = out_valid_r & out_tready;

  // update state with the result register free this cycle
  assign do_update = (state_r == ST_UPDATE) && (!out_valid_r || out_tready);

  always_comb begin
    lim = active_r;
    if (active_r == '0) begin
      lim = CFG_W'(1);
    end else if (active_r > CFG_W'(MAX_IDX)) begin
      lim = CFG_W'(MAX_IDX);
    end
  end

  assign cand_en   = (32'(cnt_r) < 32'(lim));
  assign ctl.shift = (state_r == ST_SCAN);
  assign ctl.clear = cfg_acc;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_SCAN;
          cnt_nxt   = '0;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == LAST_CNT) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (do_update) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      active_r    <= CFG_W'(16);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_acc) begin
        active_r <= cfg_tdata[CFG_W-1:0];
      end
      if (do_update) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      dur_r <= in_tdata;
    end
    if (do_update) begin
      out_start_r <= min_val;
      out_idx_r   <= min_idx;
    end
  end

  // saturating advance of the winner's free time
  assign sum       = {1'b0, min_val} + {{(TIME_W + 1 - DUR_W){1'b0}}, dur_r};
  assign next_time = sum[TIME_W] ? '1 : sum[TIME_W-1:0];

  // ring: cell i takes cell i+1; cell 0 is the head seen by the comparator
  for (genvar i = 0; i < NUM_WORKERS; i++) begin : g_cell
    localparam bit CAN_WIN = (i < MAX_IDX);
    logic wr_en;
    assign wr_en = do_update && CAN_WIN && (min_idx == WIDX_W'(i));
    efws_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .shift_in (cell_val[(i + 1) % NUM_WORKERS]),
      .wr_en    (wr_en),
      .wr_data  (next_time),
      .value    (cell_val[i])
    );
  end

  efws_min u_min (
    .clk      (clk),
    .first    ((state_r == ST_SCAN) && (cnt_r == '0)),
    .cand_en  ((state_r == ST_SCAN) && cand_en),
    .cand_val (cell_val[0]),
    .cand_idx (WIDX_W'(cnt_r)),
    .min_val  (min_val),
    .min_idx  (min_idx)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_start_r, out_idx_r};

endmodule

[verif/testbench.sv]
// Testbench for earliest_free_worker_scheduler: job duration words in, worker/start words out.
// Depends on efws_pkg; a local scheduling predictor, or the result given in a row, checks every result word in order.
// Covers worker counts, long busy times and heavy output back-pressure.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import efws_pkg::*;

  localparam int NUM_WORKERS = 16;
  localparam int QUIET_LIMIT = 2000;   // cycles with no word moving on any channel
  localparam int SETTLE      = 24;     // pause before a worker-count write
  localparam int HOLD_CYCLES = 400;    // long sink stall to back up the input
  localparam int PHASE_JOBS  = 200;
  localparam int TAIL_JOBS   = 24;

  typedef struct packed {
    widx_t worker;
    time_t start;
  } assignment_t;

  typedef struct packed {
    dur_t  dur;
    bit    typed;   // expected result given in the row
    widx_t worker;
    time_t start;
  } job_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_tdata;   // [4:0] active_workers
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;    // [31:0] job_duration
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;   // [3:0] worker_index, [51:4] start_time, [55:52] zero

  earliest_free_worker_scheduler #(.NUM_WORKERS(NUM_WORKERS)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_tdata  (cfg_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // predictor state
  time_t       free_at [NUM_WORKERS];
  cfg_t        worker_count;
  assignment_t pending_jobs [$];

  int unsigned jobs_sent;
  int unsigned words_out;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  bit          no_gaps;
  bit          held_once;

  // first sixteen rows land on workers 0..15 at time zero; the rest go to the predictor
  job_row_t dir_rows [20] = '{
    '{32'hFFFF_FFFF, 1'b1, 4'd0,  48'd0},
    '{32'h0000_0001, 1'b1, 4'd1,  48'd0},
    '{32'h8000_0000, 1'b1, 4'd2,  48'd0},
    '{32'h7FFF_FFFF, 1'b1, 4'd3,  48'd0},
    '{32'h5555_5555, 1'b1, 4'd4,  48'd0},
    '{32'hAAAA_AAAA, 1'b1, 4'd5,  48'd0},
    '{32'h0000_FFFF, 1'b1, 4'd6,  48'd0},
    '{32'hFFFF_0000, 1'b1, 4'd7,  48'd0},
    '{32'h0000_0002, 1'b1, 4'd8,  48'd0},
    '{32'h0000_0003, 1'b1, 4'd9,  48'd0},
    '{32'h0000_0064, 1'b1, 4'd10, 48'd0},
    '{32'h0000_0005, 1'b1, 4'd11, 48'd0},
    '{32'h0000_0007, 1'b1, 4'd12, 48'd0},
    '{32'h0000_03E8, 1'b1, 4'd13, 48'd0},
    '{32'h0000_000A, 1'b1, 4'd14, 48'd0},
    '{32'h0000_0004, 1'b1, 4'd15, 48'd0},
    '{32'h0000_0000, 1'b0, 4'd0,  48'd0},
    '{32'h0000_0000, 1'b0, 4'd0,  48'd0},
    '{32'h0000_0001, 1'b0, 4'd0,  48'd0},
    '{32'hFFFF_FFFF, 1'b0, 4'd0,  48'd0}
  };

  logic [7:0] phase_counts [9] = '{8'h01, 8'h10, 8'hFF, 8'h02, 8'hE3, 8'h11, 8'h00, 8'h00, 8'h00};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // earliest-free pick, lowest index on a tie, free time saturating at 2^48-1
  function automatic assignment_t schedule_job(input dur_t dur);
    assignment_t res;
    int unsigned n;
    int unsigned best;
    logic [TIME_W:0] sum;
    n = worker_count;
    if (n == 0) n = 1;
    if (n > NUM_WORKERS) n = NUM_WORKERS;
    if (n > MAX_IDX) n = MAX_IDX;
    best = 0;
    for (int i = 1; i < n; i++)
      if (free_at[i] < free_at[best]) best = i;
    res.worker = best[WIDX_W-1:0];
    res.start  = free_at[best];
    sum = {1'b0, free_at[best]} + {{(TIME_W+1-DUR_W){1'b0}}, dur};
    free_at[best] = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    return res;
  endfunction

  // a run of gap-free words every hundred, random waits otherwise
  function automatic int unsigned pick_gap(input int unsigned seq);
    if (no_gaps || (seq % 100) < 25) return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic dur_t pick_duration();
    case ($urandom_range(0, 9))
      0, 1:       return $urandom_range(0, 3);
      2, 3, 4, 5: return $urandom_range(0, 1000);
      6, 7:       return $urandom();
      8:          return 32'hFFFF_FFFF;
      default:    return 32'h0;
    endcase
  endfunction

  task automatic report(input string msg);
    if (mismatches < 10) $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic send_job(input dur_t dur, input bit typed, input assignment_t given);
    int unsigned gap;
    assignment_t res;
    gap = pick_gap(jobs_sent);
    if (gap != 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= dur;
    do @(posedge clk); while (!in_tready);
    res = schedule_job(dur);
    pending_jobs.insert(pending_jobs.size(), typed ? given : res);
    jobs_sent++;
  endtask

  task automatic write_workers(input logic [7:0] val);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_jobs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_tdata <= val;
    do @(posedge clk); while (!cfg_ready);
    worker_count = val[CFG_W-1:0];
    foreach (free_at[i]) free_at[i] = '0;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    assignment_t want;
    if (rst_n && out_tvalid && out_tready) begin
      words_out <= words_out + 1;
      if (pending_jobs.size() == 0) begin
        report($sformatf("unexpected word %h", out_tdata));
      end else begin
        want = pending_jobs.pop_front();
        if (out_tdata[3:0] !== want.worker)
          report($sformatf("worker_index exp %0d got %0d", want.worker, out_tdata[3:0]));
        if (out_tdata[51:4] !== want.start)
          report($sformatf("start_time exp %h got %h", want.start, out_tdata[51:4]));
        if (out_tdata[55:52] !== 4'h0)
          report($sformatf("padding exp 0 got %h", out_tdata[55:52]));
      end
    end
  end

  // watchdog on cycles where no word moves
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // result sink: random stalls, one long hold-off while the source keeps pushing
  initial begin
    int unsigned gap;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      gap = pick_gap(words_out);
      if (!held_once && words_out >= 120) begin
        gap = HOLD_CYCLES;
        held_once = 1'b1;
      end
      if (gap != 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    assignment_t none;
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_tdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    jobs_sent  = 0;
    words_out  = 0;
    mismatches = 0;
    no_gaps    = 1'b0;
    held_once  = 1'b0;
    none       = '0;
    worker_count = 5'd16;
    foreach (free_at[i]) free_at[i] = '0;
    for (int i = 6; i < 9; i++) phase_counts[i] = 8'($urandom_range(0, 255));
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_job(dir_rows[i].dur, dir_rows[i].typed, {dir_rows[i].worker, dir_rows[i].start});

    foreach (phase_counts[p]) begin
      write_workers(phase_counts[p]);
      repeat (PHASE_JOBS) send_job(pick_duration(), 1'b0, none);
    end

    // one worker (count 0): back-to-back maximum durations pile onto worker 0
    write_workers(8'h00);
    no_gaps = 1'b1;
    repeat (TAIL_JOBS) send_job(32'hFFFF_FFFF, 1'b0, none);
    send_job(32'h0000_FFFF, 1'b0, none);
    send_job(32'h0000_0000, 1'b0, none);
    no_gaps = 1'b0;

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_jobs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && pending_jobs.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
